// ----- design/octahedral_normal_unpack_assert.svh -----
// assertion macros shared by the checker
`ifndef OCTAHEDRAL_NORMAL_UNPACK_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_UNPACK_ASSERT_SVH

// checked outside reset
`define ONU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ONU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/onu_pkg.sv -----
// shared widths and types for the octahedral normal unpacker
package onu_pkg;
  localparam int BYTE_W  = 8;
  localparam int COMP_W  = 11;
  localparam int SQ_W    = 20;
  localparam int LANES   = 3;
  localparam int OUT_W   = 16;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [SQ_W-1:0]          sq_t;
endpackage

// ----- design/octahedral_normal_unpack.sv -----
// octahedral 16-bit normal decode: one request per cycle.
// Each request is decoded, squared, then every component goes through FRAC_BITS+1
// digit stages that find the rounded quotient c/|v| one bit per stage using only
// shifts and adds, so one normal enters and one leaves every cycle; the latency is set
// by the length of that digit pipeline. A stall on the output holds the whole pipe.
module octahedral_normal_unpack
  import onu_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // packed_bits[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  output logic        out_tuser   // binormal_negative
);

  localparam int NS = FRAC_BITS + 1;
  localparam int W  = 2 * FRAC_BITS + 26;
  localparam int EW = NS + OUT_W;

  logic en;

  // stage 0: decode and fold
  logic  s0_vld_r;
  logic  s0_neg_r;
  comp_t s0_c_r [0:LANES-1];

  logic [BYTE_W-1:0] bx, by;
  logic              neg_nxt;
  comp_t             px, py, pz, ax, ay, fx, fy;

  always_comb begin
    bx = in_tdata[BYTE_W-1:0];
    by = in_tdata[2*BYTE_W-1:BYTE_W];
    neg_nxt = bx[BYTE_W-1] & by[BYTE_W-1];
    if (neg_nxt) begin
      bx[BYTE_W-1] = 1'b0;
      by[BYTE_W-1] = 1'b0;
    end
    px = $signed({2'b00, bx, 1'b0}) - comp_t'(127);
    py = $signed({2'b00, by, 1'b0}) - comp_t'(127);
    ax = px[COMP_W-1] ? -px : px;
    ay = py[COMP_W-1] ? -py : py;
    pz = comp_t'(127) - ax - ay;
    fx = px;
    fy = py;
    if (pz[COMP_W-1]) begin
      fx = (px > 0) ? (comp_t'(127) - ay) : (ay - comp_t'(127));
      fy = (py > 0) ? (comp_t'(127) - ax) : (ax - comp_t'(127));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_neg_r  <= neg_nxt;
      s0_c_r[0] <= fx;
      s0_c_r[1] <= fy;
      s0_c_r[2] <= pz;
    end
  end

  // stage 1: squares
  logic s1_vld_r;
  logic s1_neg_r;
  logic s1_sgn_r [0:LANES-1];
  sq_t  s1_sq_r  [0:LANES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_sq
    logic signed [2*COMP_W-1:0] prod;
    assign prod = s0_c_r[l] * s0_c_r[l];
    always_ff @(posedge clk) begin
      if (en) begin
        s1_sq_r[l]  <= prod[SQ_W-1:0];
        s1_sgn_r[l] <= s0_c_r[l][COMP_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_r <= s0_neg_r;
    end
  end

  // digit pipeline, index 0 is the setup stage
  logic           vld_r [0:NS];
  logic           neg_r [0:NS];
  logic [W-1:0]   nsq_r [0:NS];
  logic           sgn_r [0:NS][0:LANES-1];
  logic [W-1:0]   tgt_r [0:NS][0:LANES-1];
  logic [W-1:0]   acc_a_r [0:NS][0:LANES-1];
  logic [W-1:0]   acc_b_r [0:NS][0:LANES-1];
  logic [NS-1:0]  quo_r [0:NS][0:LANES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= s1_neg_r;
      nsq_r[0] <= W'(s1_sq_r[0]) + W'(s1_sq_r[1]) + W'(s1_sq_r[2]);
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_setup
    always_ff @(posedge clk) begin
      if (en) begin
        sgn_r[0][l]   <= s1_sgn_r[l];
        tgt_r[0][l]   <= W'(s1_sq_r[l]) << (2 * FRAC_BITS + 2);
        acc_a_r[0][l] <= '0;
        acc_b_r[0][l] <= '0;
        quo_r[0][l]   <= '0;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_dig
    localparam int K = FRAC_BITS - s;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[s+1] <= neg_r[s];
        nsq_r[s+1] <= nsq_r[s];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [W-1:0] a_nxt, b_nxt, trial;
      logic         take;

      always_comb begin
        a_nxt = acc_a_r[s][l] + (acc_b_r[s][l] << (K + 1)) + (nsq_r[s] << (2 * K));
        b_nxt = acc_b_r[s][l] + (nsq_r[s] << K);
        trial = (a_nxt << 2) - (b_nxt << 2) + nsq_r[s];
        take  = (trial <= tgt_r[s][l]);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sgn_r[s+1][l] <= sgn_r[s][l];
          tgt_r[s+1][l] <= tgt_r[s][l];
          if (take) begin
            acc_a_r[s+1][l] <= a_nxt;
            acc_b_r[s+1][l] <= b_nxt;
            quo_r[s+1][l]   <= quo_r[s][l] | (NS'(1) << K);
          end else begin
            acc_a_r[s+1][l] <= acc_a_r[s][l];
            acc_b_r[s+1][l] <= acc_b_r[s][l];
            quo_r[s+1][l]   <= quo_r[s][l];
          end
        end
      end
    end
  end

  // output register
  logic              out_vld_r;
  logic              out_neg_r;
  logic [OUT_W-1:0]  out_val_r [0:LANES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NS];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    logic [EW-1:0] ext, val;
    assign ext = EW'(quo_r[NS][l]);
    assign val = sgn_r[NS][l] ? (~ext + EW'(1)) : ext;
    always_ff @(posedge clk) begin
      if (en) begin
        out_val_r[l] <= val[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_neg_r <= neg_r[NS];
    end
  end

  assign en         = !out_vld_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_val_r[2], out_val_r[1], out_val_r[0]};
  assign out_tuser  = out_neg_r;

endmodule

// ----- design/onu_checker.sv -----
// port-level checker for the octahedral normal unpacker, with its bind
`include "octahedral_normal_unpack_assert.svh"
module onu_checker
  import onu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  `ONU_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `ONU_ASSERT(a_hold_valid, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `ONU_ASSERT(a_hold_data, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")
  `ONU_ASSERT(a_ready_free, !out_tvalid |-> in_tready, "input stalled with empty output")

endmodule

bind octahedral_normal_unpack onu_checker u_onu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/octahedral_normal_unpack_checker.sv -----
// checker: predicts each decoded normal from the accepted request and compares results
module octahedral_normal_unpack_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        bneg;
  } normal_t;

  normal_t expected_normals[$];

  function automatic logic [15:0] scale_component(int c, longint nsq);
    longint mag, lo, hi, mid, odd, rhs;
    mag = (c < 0) ? -c : c;
    rhs = (64'(2) << FRAC) * mag;
    rhs = rhs * rhs;
    lo = 0;
    hi = longint'(1) << FRAC;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 2 * mid - 1;
      if (odd * odd * nsq <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (c < 0) lo = -lo;
    return lo[15:0];
  endfunction

  function automatic normal_t decode_normal(logic [15:0] bits);
    int bx, by, px, py, pz, fx, fy, ax, ay;
    longint nsq;
    normal_t r;
    bx = bits[7:0];
    by = bits[15:8];
    r.bneg = (bx > 127) && (by > 127);
    if (r.bneg) begin
      bx -= 128;
      by -= 128;
    end
    px = 2 * bx - 127;
    py = 2 * by - 127;
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    pz = 127 - ax - ay;
    fx = px;
    fy = py;
    if (pz < 0) begin
      fx = (px > 0) ? (127 - ay) : -(127 - ay);
      fy = (py > 0) ? (127 - ax) : -(127 - ax);
    end
    nsq = longint'(fx) * fx + longint'(fy) * fy + longint'(pz) * pz;
    r.nx = scale_component(fx, nsq);
    r.ny = scale_component(fy, nsq);
    r.nz = scale_component(pz, nsq);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    normal_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_normals.push_back(decode_normal(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_normals.size() == 0) begin
          $display("unexpected result %h at %0t", out_tdata, $realtime);
          fail_count++;
        end else begin
          want = expected_normals.pop_front();
          if (out_tdata[15:0] !== want.nx) report_mismatch("normal_x", out_tdata[15:0], want.nx);
          if (out_tdata[31:16] !== want.ny)
            report_mismatch("normal_y", out_tdata[31:16], want.ny);
          if (out_tdata[47:32] !== want.nz)
            report_mismatch("normal_z", out_tdata[47:32], want.nz);
          if (out_tuser !== want.bneg)
            report_mismatch("binormal_negative", 16'(out_tuser), 16'(want.bneg));
        end
      end
      pending_count = expected_normals.size();
    end
  end
endmodule

// ----- tb/sv/octahedral_normal_unpack_tb.sv -----
// testbench top: drives packed normals through the unpacker and gives the verdict
module octahedral_normal_unpack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 19;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  octahedral_normal_unpack DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  octahedral_normal_unpack_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_normal(logic [15:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= bits;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_normal();
    case ($urandom_range(4))
      0: return {8'($urandom_range(128, 255)), 8'($urandom_range(128, 255))};
      1: return {8'($urandom_range(0, 127)), 8'($urandom_range(128, 255))};
      2: return {8'($urandom_range(128, 255)), 8'($urandom_range(0, 127))};
      3: return {8'($urandom_range(0, 127)), 8'($urandom_range(0, 127))};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] corner_bits[$];
    corner_bits = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h7F7F, 16'h8080,
                    16'h7F80, 16'h807F, 16'h8000, 16'h0080, 16'h4040, 16'h3F3F,
                    16'h4000, 16'h0040, 16'hC0C0, 16'hBFBF, 16'hFF80, 16'h80FF,
                    16'h7F00, 16'h007F, 16'hAA55, 16'h55AA};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_bits[i]) send_normal(corner_bits[i]);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (210) send_normal(random_normal());
      if (ph == 1) begin
        go_idle();
        while (pending_count != 0) @(posedge clk);
      end
    end
    go_idle();
    recv_stall_pct = 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
